>>> rtl/thc_pkg.sv
// Shared constants, types and helpers for the tar header checker.
package thc_pkg;

    localparam int BLOCK_BYTES = 512;
    localparam int OFF_W       = $clog2(BLOCK_BYTES);
    localparam int NUM_W       = 36;
    localparam int SUM_W       = 17;
    localparam int CHK_W       = 24;

    localparam logic [OFF_W-1:0] LAST_OFF  = OFF_W'(BLOCK_BYTES - 1);
    localparam logic [OFF_W-1:0] SIZE_OFF  = OFF_W'(124);
    localparam logic [OFF_W-1:0] SIZE_END  = OFF_W'(135);
    localparam logic [OFF_W-1:0] TIME_OFF  = OFF_W'(136);
    localparam logic [OFF_W-1:0] TIME_END  = OFF_W'(147);
    localparam logic [OFF_W-1:0] CHK_OFF   = OFF_W'(148);
    localparam logic [OFF_W-1:0] CHK_END   = OFF_W'(155);
    localparam logic [OFF_W-1:0] TYPE_OFF  = OFF_W'(156);
    localparam logic [OFF_W-1:0] MAGIC_OFF = OFF_W'(257);
    localparam logic [OFF_W-1:0] MAGIC_END = OFF_W'(262);

    localparam logic [7:0] CHK_FILL = 8'd32;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_END_ARCHIVE = 2'd1,
        ST_BAD_MAGIC   = 2'd2,
        ST_CHECKSUM    = 2'd3
    } t_status;

    typedef struct packed {
        t_status           status;
        logic [7:0]        entry_type;
        logic [NUM_W-1:0]  file_size;
        logic [NUM_W-1:0]  modified_time;
    } t_result;

    // Expected byte of "ustar" and its terminating zero.
    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h75;
            3'd1:    ch = 8'h73;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h61;
            3'd4:    ch = 8'h72;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

>>> rtl/thc_in_if.sv
// Header byte channel: valid/ready handshake with one byte of payload.
interface thc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

>>> rtl/thc_out_if.sv
// Result channel: valid/ready handshake with status and decoded fields.
interface thc_out_if;
    import thc_pkg::*;

    logic             valid;
    logic             ready;
    t_status          status;
    logic [7:0]       entry_type;
    logic [NUM_W-1:0] file_size;
    logic [NUM_W-1:0] modified_time;

    modport source (output valid, output status, output entry_type,
                    output file_size, output modified_time, input ready);
    modport sink   (input valid, input status, input entry_type,
                    input file_size, input modified_time, output ready);
endinterface

>>> rtl/thc_octal_field.sv
// Octal field parser: skips leading whitespace, then reads digits until a non-digit.
module thc_octal_field (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_clear,
    input  logic [7:0]               i_byte,
    output logic [thc_pkg::NUM_W-1:0] o_value
);
    import thc_pkg::*;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [NUM_W-1:0] r_acc, n_acc;
    logic             is_digit, is_space;

    always_comb begin
        is_digit = i_byte inside {[8'h30:8'h37]};
        is_space = i_byte inside {8'h20, [8'h09:8'h0D]};
        n_phase  = r_phase;
        n_acc    = r_acc;
        if (i_clear) begin
            n_phase = PH_SKIP;
            n_acc   = '0;
        end else if (i_en) begin
            case (r_phase)
                PH_SKIP: begin
                    if (is_digit) begin
                        n_acc   = {{(NUM_W-3){1'b0}}, i_byte[2:0]};
                        n_phase = PH_DIGITS;
                    end else if (!is_space) begin
                        n_phase = PH_DONE;
                    end
                end
                PH_DIGITS: begin
                    if (is_digit) begin
                        n_acc = {r_acc[NUM_W-4:0], i_byte[2:0]};
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                default: n_phase = PH_DONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP;
            r_acc   <= '0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
        end
    end

    assign o_value = r_acc;

endmodule

>>> rtl/thc_header_core.sv
// Per-byte header state: offset, checksum sums, magic, type and octal fields.
module thc_header_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [7:0]         i_byte,
    output logic               o_last,
    output thc_pkg::t_result   o_result
);
    import thc_pkg::*;

    logic [OFF_W-1:0] r_offset;
    logic [SUM_W-1:0] r_utot, n_utot;
    logic [SUM_W-1:0] r_stot, n_stot;
    logic             r_lead_zero;
    logic             r_magic_good;
    logic [7:0]       r_type;

    logic             in_size, in_time, in_chk, in_magic;
    logic [OFF_W-1:0] magic_idx;
    logic             clear;
    logic             sum_ok;
    logic [NUM_W-1:0] size_val, time_val, chk_val;
    t_status          status;

    assign o_last   = (r_offset == LAST_OFF);
    assign clear    = i_fire && o_last;
    assign in_size  = r_offset inside {[SIZE_OFF:SIZE_END]};
    assign in_time  = r_offset inside {[TIME_OFF:TIME_END]};
    assign in_chk   = r_offset inside {[CHK_OFF:CHK_END]};
    assign in_magic = r_offset inside {[MAGIC_OFF:MAGIC_END]};
    assign magic_idx = r_offset - MAGIC_OFF;

    // Checksum bytes count as spaces in both sums.
    always_comb begin
        if (in_chk) begin
            n_utot = r_utot + {{(SUM_W-8){1'b0}}, CHK_FILL};
            n_stot = r_stot + {{(SUM_W-8){1'b0}}, CHK_FILL};
        end else begin
            n_utot = r_utot + {{(SUM_W-8){1'b0}}, i_byte};
            n_stot = r_stot + {{(SUM_W-8){i_byte[7]}}, i_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear) begin
            r_offset     <= '0;
            r_utot       <= '0;
            r_stot       <= '0;
            r_lead_zero  <= 1'b0;
            r_magic_good <= 1'b1;
            r_type       <= '0;
        end else if (i_fire) begin
            r_offset <= r_offset + 1'b1;
            r_utot   <= n_utot;
            r_stot   <= n_stot;
            if (r_offset == '0) begin
                r_lead_zero <= (i_byte == 8'h00);
            end
            if (r_offset == TYPE_OFF) begin
                r_type <= i_byte;
            end
            if (in_magic && (i_byte != magic_byte(magic_idx[2:0]))) begin
                r_magic_good <= 1'b0;
            end
        end
    end

    thc_octal_field u_size (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_fire && in_size),
        .i_clear (clear),
        .i_byte  (i_byte),
        .o_value (size_val)
    );

    thc_octal_field u_time (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_fire && in_time),
        .i_clear (clear),
        .i_byte  (i_byte),
        .o_value (time_val)
    );

    thc_octal_field u_chk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_fire && in_chk),
        .i_clear (clear),
        .i_byte  (i_byte),
        .o_value (chk_val)
    );

    // The stored checksum has at most eight digits, so its upper bits stay zero.
    always_comb begin
        sum_ok = (chk_val[CHK_W-1:0] == {{(CHK_W-SUM_W){1'b0}}, n_utot}) ||
                 (!n_stot[SUM_W-1] &&
                  (chk_val[CHK_W-1:0] == {{(CHK_W-SUM_W){1'b0}}, n_stot}));
        if (r_lead_zero) begin
            status = ST_END_ARCHIVE;
        end else if (!r_magic_good) begin
            status = ST_BAD_MAGIC;
        end else if (!sum_ok) begin
            status = ST_CHECKSUM;
        end else begin
            status = ST_OK;
        end
        o_result.status = status;
        if (status == ST_OK) begin
            o_result.entry_type    = r_type;
            o_result.file_size     = size_val;
            o_result.modified_time = time_val;
        end else begin
            o_result.entry_type    = '0;
            o_result.file_size     = '0;
            o_result.modified_time = '0;
        end
    end

endmodule

>>> rtl/tar_header_checker_top.sv
// Top level: input register, header core and result register.
// A result is registered when byte 511 advances from the input register, which needs a free result register.
// Throughput: one header byte per cycle unless a held result stalls byte 511; one result
// per 512 bytes, with sums and field parsers updated between the two registers.
// A stalled result stalls input only when byte 511 waits in the input register.
// Reset is synchronous, active low: offset, sums, flags and parsers return to start.
module tar_header_checker_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    thc_in_if.sink      i_hdr,
    thc_out_if.source   o_res
);
    import thc_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out_res;

    logic       core_last;
    t_result    core_res;
    logic       advance;

    // Byte 511 needs a free result register; every other byte moves on at once.
    assign advance     = r_in_valid && (!core_last || !r_out_valid || o_res.ready);
    assign i_hdr.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_hdr.ready) begin
            r_in_valid <= i_hdr.valid;
        end
        if (i_hdr.valid && i_hdr.ready) begin
            r_in_byte <= i_hdr.data_byte;
        end
    end

    thc_header_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_byte   (r_in_byte),
        .o_last   (core_last),
        .o_result (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && core_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && core_last) begin
            r_out_res <= core_res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_out_res.status;
    assign o_res.entry_type    = r_out_res.entry_type;
    assign o_res.file_size     = r_out_res.file_size;
    assign o_res.modified_time = r_out_res.modified_time;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && core_last) |-> (!r_out_valid || o_res.ready))
        else $error("result register overwritten while held");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(advance && core_last))
        else $error("result appeared without a final header byte");

    a_clean_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_res.status != ST_OK)) |->
        (r_out_res.entry_type == '0 && r_out_res.file_size == '0 &&
         r_out_res.modified_time == '0))
        else $error("non-ok result carries field data");

    a_take_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_hdr.valid && i_hdr.ready) |=> r_in_valid)
        else $error("accepted request lost from input register");
`endif

endmodule
